@@ sv/segment_retransmit_tracker_top_macros.svh @@
// ----------------------------------------------------------------------------
// Segment retransmit tracker assertion macros
// Short forms for the clocked, reset-qualified properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_RETRANSMIT_TRACKER_TOP_MACROS_SVH
`define SEGMENT_RETRANSMIT_TRACKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/srt_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment retransmit tracker package
// Field widths, request and status codes, and the controller interface types.
// ----------------------------------------------------------------------------
package srt_pkg;

	localparam int MAX_SEGMENTS_DEF = 1024;

	localparam int REQ_W      = 3;
	localparam int INDEX_W    = 16;
	localparam int STATUS_W   = 3;
	localparam int FOUND_W    = 10;
	localparam int OFFSET_W   = 26;
	localparam int LENGTH_W   = 16;
	localparam int PENDING_W  = 11;
	localparam int SEG_SIZE_W = 16;
	localparam int MSG_SIZE_W = 32;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// The bitmap is stored as rows of one word each.
	localparam int WORD_W    = 32;
	localparam int WORD_LOG  = 5;
	localparam int DIV_STEPS = 32;

	localparam logic [SEG_SIZE_W-1:0] SEG_SIZE_RST = 16'd1024;
	localparam logic [MSG_SIZE_W-1:0] MSG_SIZE_RST = 32'd0;

	localparam logic REG_SEG_SIZE = 1'b0;
	localparam logic REG_MSG_SIZE = 1'b1;

	localparam logic [REQ_W-1:0] REQ_INIT   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ACK    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RETX   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_INIT    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_PENDING = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_MANY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IGNORED     = 3'd4;

	typedef struct packed {
		logic                capture;
		logic                div_start;
		logic                init_commit;
		logic                sweep_en;
		logic                set_ready;
		logic                map_clear;
		logic                map_set;
		logic                stage_seg;
		logic                stage_status;
		logic [STATUS_W-1:0] status;
		logic                mul_en;
		logic                out_load;
	} srt_cmd_t;

	typedef struct packed {
		logic req_init;
		logic req_next;
		logic req_lookup;
		logic req_ack;
		logic req_retx;
		logic ready;
		logic in_range;
		logic any_pending;
		logic bit_set;
		logic div_done;
		logic too_many;
		logic sweep_last;
		logic out_free;
	} srt_stat_t;

endpackage

@@ sv/srt_div.sv @@
// ----------------------------------------------------------------------------
// Segment retransmit tracker divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srt_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [srt_pkg::MSG_SIZE_W-1:0] dividend,
	input  logic [srt_pkg::SEG_SIZE_W-1:0] divisor,
	output logic [srt_pkg::MSG_SIZE_W-1:0] quotient,
	output logic                           rem_nz,
	output logic                           done
);
	import srt_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS);

	logic [MSG_SIZE_W-1:0] quo_q;
	logic [SEG_SIZE_W-1:0] rem_q;
	logic [SEG_SIZE_W-1:0] dvs_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [SEG_SIZE_W:0]   shifted;
	logic [SEG_SIZE_W:0]   diff;
	logic                  fits;

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	assign shifted = {rem_q, quo_q[MSG_SIZE_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MSG_SIZE_W-2:0], fits};
			rem_q <= fits ? diff[SEG_SIZE_W-1:0] : shifted[SEG_SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign quotient = quo_q;
	assign rem_nz   = |rem_q;
	assign done     = done_q;

endmodule

@@ sv/srt_map.sv @@
// ----------------------------------------------------------------------------
// Segment retransmit tracker pending map
// Bitmap memory in word rows with a per-row summary of rows holding set bits.
// ----------------------------------------------------------------------------
module srt_map #(
	parameter int ROWS   = 32,
	parameter int ROW_AW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [ROW_AW-1:0]          wr_row,
	input  logic [srt_pkg::WORD_W-1:0] wr_word,
	input  logic                       rd_en,
	input  logic [ROW_AW-1:0]          rd_row,
	output logic [srt_pkg::WORD_W-1:0] rd_word,
	output logic [ROW_AW-1:0]          first_row,
	output logic                       any_set
);
	import srt_pkg::*;

	logic [WORD_W-1:0] mem_q [ROWS];
	logic [WORD_W-1:0] rd_word_q;
	logic [ROWS-1:0]   sum_q;

	// Rows can be read before the init sweep, but a read word is used only after it has written all of them.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_row] <= wr_word;
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (wr_en) begin
			sum_q[wr_row] <= |wr_word;
		end
	end

	always_comb begin
		first_row = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (sum_q[i]) begin
				first_row = ROW_AW'(i);
			end
		end
	end

	assign any_set = |sum_q;
	assign rd_word = rd_word_q;

endmodule

@@ sv/srt_dp.sv @@
// ----------------------------------------------------------------------------
// Segment retransmit tracker datapath
// Request capture, counters, bitmap updates, offset multiply and result register.
// ----------------------------------------------------------------------------
module srt_dp #(
	parameter int MAX_SEGMENTS = srt_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srt_pkg::srt_cmd_t              cmd,
	output srt_pkg::srt_stat_t             stat,
	input  logic [srt_pkg::SEG_SIZE_W-1:0] seg_size,
	input  logic [srt_pkg::MSG_SIZE_W-1:0] msg_size,
	input  logic [srt_pkg::REQ_W-1:0]      req_type,
	input  logic [srt_pkg::INDEX_W-1:0]    seg_index,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [srt_pkg::STATUS_W-1:0]   status,
	output logic [srt_pkg::FOUND_W-1:0]    found_index,
	output logic [srt_pkg::OFFSET_W-1:0]   seg_offset,
	output logic [srt_pkg::LENGTH_W-1:0]   seg_length,
	output logic [srt_pkg::PENDING_W-1:0]  pending_left
);
	import srt_pkg::*;

	localparam int ROWS    = (MAX_SEGMENTS + WORD_W - 1) / WORD_W;
	localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W   = ROW_AW + WORD_LOG;
	localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
	localparam int CMP_W   = ((IDX_W + 1) > CNT_W) ? (IDX_W + 1) : CNT_W;
	localparam int RANGE_W = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;
	localparam int QCNT_W  = MSG_SIZE_W + 1;

	logic [REQ_W-1:0]      req_q;
	logic [INDEX_W-1:0]    idx_q;
	logic [ROW_AW-1:0]     row_q;
	logic                  in_range_q;
	logic                  any_q;
	logic                  ready_q;
	logic [CNT_W-1:0]      seg_total_q;
	logic [CNT_W-1:0]      pend_total_q;
	logic [ROW_AW-1:0]     sweep_q;
	logic [SEG_SIZE_W-1:0] lseg_q;
	logic [MSG_SIZE_W-1:0] lmsg_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  res_seg_q;
	logic [IDX_W-1:0]      res_found_q;
	logic [MSG_SIZE_W-1:0] off_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [FOUND_W-1:0]    out_found_q;
	logic [OFFSET_W-1:0]   out_off_q;
	logic [LENGTH_W-1:0]   out_len_q;
	logic [PENDING_W-1:0]  out_pend_q;

	logic [SEG_SIZE_W-1:0] seg_eff;
	logic [MSG_SIZE_W-1:0] quotient;
	logic                  rem_nz;
	logic                  div_done;
	logic [QCNT_W-1:0]     count;
	logic [ROW_AW-1:0]     rd_row;
	logic [ROW_AW-1:0]     first_row;
	logic                  any_set;
	logic [WORD_W-1:0]     rd_word;
	logic                  wr_en;
	logic [ROW_AW-1:0]     wr_row;
	logic [WORD_W-1:0]     wr_word;
	logic [WORD_W-1:0]     fill_word;
	logic [WORD_W-1:0]     bit_mask;
	logic [WORD_LOG-1:0]   bit_pos;
	logic [WORD_LOG-1:0]   low_bit;
	logic                  bit_set;
	logic [CMP_W-1:0]      fill_base;
	logic [CMP_W-1:0]      fill_cnt;
	logic [CMP_W-1:0]      fill_n;
	logic [MSG_SIZE_W-1:0] tail;
	logic [LENGTH_W-1:0]   len;
	logic                  out_free;

	// A zero segment size behaves as a size of one byte.
	assign seg_eff = (seg_size == '0) ? SEG_SIZE_W'(1) : seg_size;

	srt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (msg_size),
		.divisor  (seg_eff),
		.quotient (quotient),
		.rem_nz   (rem_nz),
		.done     (div_done)
	);

	// Segment count rounds up when the division leaves a remainder.
	assign count = {1'b0, quotient} + QCNT_W'(rem_nz);

	assign rd_row  = (req_type == REQ_NEXT) ? first_row : seg_index[WORD_LOG +: ROW_AW];
	assign bit_pos = idx_q[WORD_LOG-1:0];
	assign bit_set = rd_word[bit_pos];
	assign bit_mask = WORD_W'(1) << bit_pos;

	always_comb begin
		low_bit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (rd_word[i]) begin
				low_bit = WORD_LOG'(i);
			end
		end
	end

	// Init fill: each row gets ones for every segment below the count.
	assign fill_base = CMP_W'({sweep_q, {WORD_LOG{1'b0}}});
	assign fill_cnt  = CMP_W'(seg_total_q);
	assign fill_n    = fill_cnt - fill_base;

	always_comb begin
		if (fill_cnt >= fill_base + CMP_W'(WORD_W)) begin
			fill_word = '1;
		end else if (fill_cnt > fill_base) begin
			fill_word = ~({WORD_W{1'b1}} << fill_n[WORD_LOG-1:0]);
		end else begin
			fill_word = '0;
		end
	end

	assign wr_en = cmd.sweep_en | cmd.map_set | cmd.map_clear;

	always_comb begin
		if (cmd.sweep_en) begin
			wr_row  = sweep_q;
			wr_word = fill_word;
		end else if (cmd.map_set) begin
			wr_row  = row_q;
			wr_word = rd_word | bit_mask;
		end else begin
			wr_row  = row_q;
			wr_word = rd_word & ~bit_mask;
		end
	end

	srt_map #(
		.ROWS   (ROWS),
		.ROW_AW (ROW_AW)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_row    (wr_row),
		.wr_word   (wr_word),
		.rd_en     (cmd.capture),
		.rd_row    (rd_row),
		.rd_word   (rd_word),
		.first_row (first_row),
		.any_set   (any_set)
	);

	// Length runs to the message end and never beyond one full segment.
	assign tail = (lmsg_q > off_q) ? (lmsg_q - off_q) : '0;
	assign len  = (tail > MSG_SIZE_W'(lseg_q)) ? lseg_q : tail[LENGTH_W-1:0];

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q      <= req_type;
			idx_q      <= seg_index;
			row_q      <= rd_row;
			in_range_q <= RANGE_W'(seg_index) < RANGE_W'(seg_total_q);
			any_q      <= any_set;
		end
		if (cmd.div_start) begin
			lseg_q <= seg_eff;
			lmsg_q <= msg_size;
		end
		if (cmd.stage_seg) begin
			res_status_q <= ST_OK;
			res_seg_q    <= 1'b1;
			res_found_q  <= (req_q == REQ_NEXT) ? {row_q, low_bit} : idx_q[IDX_W-1:0];
		end else if (cmd.stage_status) begin
			res_status_q <= cmd.status;
			res_seg_q    <= 1'b0;
		end
		if (cmd.mul_en) begin
			off_q <= MSG_SIZE_W'(res_found_q) * MSG_SIZE_W'(lseg_q);
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_pend_q   <= PENDING_W'(pend_total_q);
			if (res_seg_q) begin
				out_found_q <= FOUND_W'(res_found_q);
				out_off_q   <= off_q[OFFSET_W-1:0];
				out_len_q   <= len;
			end else begin
				out_found_q <= '0;
				out_off_q   <= '0;
				out_len_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q      <= 1'b0;
			seg_total_q  <= '0;
			pend_total_q <= '0;
			sweep_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.init_commit) begin
				seg_total_q  <= CNT_W'(count);
				pend_total_q <= CNT_W'(count);
				sweep_q      <= '0;
			end else if (cmd.sweep_en) begin
				sweep_q <= sweep_q + ROW_AW'(1);
			end
			if (cmd.set_ready) begin
				ready_q <= 1'b1;
			end
			if (cmd.map_clear) begin
				pend_total_q <= pend_total_q - CNT_W'(1);
			end else if (cmd.map_set && !bit_set) begin
				pend_total_q <= pend_total_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.req_init    = req_q == REQ_INIT;
	assign stat.req_next    = req_q == REQ_NEXT;
	assign stat.req_lookup  = req_q == REQ_LOOKUP;
	assign stat.req_ack     = req_q == REQ_ACK;
	assign stat.req_retx    = req_q == REQ_RETX;
	assign stat.ready       = ready_q;
	assign stat.in_range    = in_range_q;
	assign stat.any_pending = any_q;
	assign stat.bit_set     = bit_set;
	assign stat.div_done    = div_done;
	assign stat.too_many    = count > QCNT_W'(MAX_SEGMENTS);
	assign stat.sweep_last  = sweep_q == ROW_AW'(ROWS - 1);
	assign stat.out_free    = out_free;

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign found_index  = out_found_q;
	assign seg_offset   = out_off_q;
	assign seg_length   = out_len_q;
	assign pending_left = out_pend_q;

endmodule

@@ sv/srt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Segment retransmit tracker controller
// Sequences each request through decode, division and sweep for init, update or multiply, and result hand-off.
// ----------------------------------------------------------------------------
module srt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  srt_pkg::srt_stat_t stat,
	output srt_pkg::srt_cmd_t  cmd
);
	import srt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_SWEEP,
		S_MUL,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d          = S_OUT;
				cmd.stage_status = 1'b1;
				cmd.status       = ST_OK;
				priority if (stat.req_init) begin
					if (stat.ready) begin
						cmd.status = ST_IGNORED;
					end else begin
						cmd.stage_status = 1'b0;
						cmd.div_start    = 1'b1;
						state_d          = S_DIV;
					end
				end else if (!(stat.req_next || stat.req_lookup || stat.req_ack
						|| stat.req_retx)) begin
					cmd.status = ST_IGNORED;
				end else if (!stat.ready) begin
					cmd.status = ST_NOT_INIT;
				end else if (stat.req_next) begin
					if (stat.any_pending) begin
						cmd.stage_status = 1'b0;
						cmd.stage_seg    = 1'b1;
						state_d          = S_MUL;
					end else begin
						cmd.status = ST_NOT_PENDING;
					end
				end else if (!stat.in_range) begin
					cmd.status = ST_IGNORED;
				end else if (stat.req_lookup) begin
					if (stat.bit_set) begin
						cmd.stage_status = 1'b0;
						cmd.stage_seg    = 1'b1;
						state_d          = S_MUL;
					end else begin
						cmd.status = ST_NOT_PENDING;
					end
				end else if (stat.req_ack) begin
					if (stat.bit_set) begin
						cmd.map_clear = 1'b1;
					end else begin
						cmd.status = ST_NOT_PENDING;
					end
				end else begin
					cmd.map_set = 1'b1;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					if (stat.too_many) begin
						cmd.stage_status = 1'b1;
						cmd.status       = ST_TOO_MANY;
						state_d          = S_OUT;
					end else begin
						cmd.init_commit = 1'b1;
						state_d         = S_SWEEP;
					end
				end
			end
			S_SWEEP: begin
				cmd.sweep_en = 1'b1;
				if (stat.sweep_last) begin
					cmd.set_ready    = 1'b1;
					cmd.stage_status = 1'b1;
					cmd.status       = ST_OK;
					state_d          = S_OUT;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/segment_retransmit_tracker_top.sv @@
// ----------------------------------------------------------------------------
// Segment retransmit tracker
// Pending-segment bitmap for one segmented message, with an APB register port.
// ----------------------------------------------------------------------------
// The block takes one request transaction at a time and returns exactly one
// result transaction for it. An acknowledge, a retransmit or any rejected
// request passes from acceptance through the registered bitmap read and the
// update or status stage to the result register; a next or lookup request
// passes through the registered bitmap read, the offset multiply and the result
// register. For an init request a restoring divider first computes the segment
// count, and the bitmap, kept as 32-bit rows in a memory with one read and one
// write port, is then filled one row per cycle. A new request is accepted as
// soon as the previous one has placed its result in the output register, even
// if that result has not yet been taken. The bitmap memory is not cleared after
// reset; its contents are not used until an init has filled it. The
// segment_size register sits at byte address 0 and message_size at byte
// address 4. Both are sampled only by an init request, and write transactions
// must only happen while the block is idle.
// ----------------------------------------------------------------------------
module segment_retransmit_tracker_top #(
	parameter int MAX_SEGMENTS = srt_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [srt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [srt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [srt_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	// Request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [srt_pkg::REQ_W-1:0]      req_type,
	input  logic [srt_pkg::INDEX_W-1:0]    seg_index,
	// Result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [srt_pkg::STATUS_W-1:0]   status,
	output logic [srt_pkg::FOUND_W-1:0]    found_index,
	output logic [srt_pkg::OFFSET_W-1:0]   seg_offset,
	output logic [srt_pkg::LENGTH_W-1:0]   seg_length,
	output logic [srt_pkg::PENDING_W-1:0]  pending_left
);
	import srt_pkg::*;

	logic [SEG_SIZE_W-1:0] seg_size_q;
	logic [MSG_SIZE_W-1:0] msg_size_q;
	logic                  reg_sel;
	logic                  cfg_wr;
	srt_cmd_t              cmd;
	srt_stat_t             stat;

	// Registers are decoded on the word address bit alone.
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_size_q <= SEG_SIZE_RST;
			msg_size_q <= MSG_SIZE_RST;
		end else if (cfg_wr) begin
			if (reg_sel == REG_SEG_SIZE) begin
				seg_size_q <= pwdata[SEG_SIZE_W-1:0];
			end else begin
				msg_size_q <= pwdata[MSG_SIZE_W-1:0];
			end
		end
	end

	assign prdata = (reg_sel == REG_MSG_SIZE) ? msg_size_q : APB_DATA_W'(seg_size_q);

	// The controller steps each request; the datapath holds the bitmap, counters and results.
	srt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	srt_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.seg_size     (seg_size_q),
		.msg_size     (msg_size_q),
		.req_type     (req_type),
		.seg_index    (seg_index),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.found_index  (found_index),
		.seg_offset   (seg_offset),
		.seg_length   (seg_length),
		.pending_left (pending_left)
	);

endmodule

@@ sv/srt_checker.sv @@
// ----------------------------------------------------------------------------
// Segment retransmit tracker port checker
// Assertions on the result channel as seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "segment_retransmit_tracker_top_macros.svh"

module srt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [srt_pkg::STATUS_W-1:0]  status,
	input logic [srt_pkg::FOUND_W-1:0]   found_index,
	input logic [srt_pkg::OFFSET_W-1:0]  seg_offset,
	input logic [srt_pkg::LENGTH_W-1:0]  seg_length,
	input logic [srt_pkg::PENDING_W-1:0] pending_left
);
	import srt_pkg::*;

	// A stalled result transaction keeps its whole payload.
	`SRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_index) && $stable(seg_offset) && $stable(seg_length) && $stable(pending_left), "result payload changed while stalled")

	// Only a successful next or lookup carries segment fields.
	`SRT_ASSERT_SAME(a_seg_fields_zero, out_valid && status != ST_OK, found_index == '0 && seg_offset == '0 && seg_length == '0, "segment fields set on a non-ok result")

	// Before a successful init nothing can be pending.
	`SRT_ASSERT_SAME(a_not_init_empty, out_valid && status == ST_NOT_INIT, pending_left == '0, "pending count nonzero while not initialized")

	// A rejected init leaves the block uninitialized.
	`SRT_ASSERT_SAME(a_too_many_empty, out_valid && status == ST_TOO_MANY, pending_left == '0, "pending count nonzero after rejected init")

endmodule

bind segment_retransmit_tracker_top srt_checker u_srt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.found_index  (found_index),
	.seg_offset   (seg_offset),
	.seg_length   (seg_length),
	.pending_left (pending_left)
);
